// File: hw/rtl/framed_packet_receiver_assert.svh
// ----------------------------------------------------------------------------
// framed_packet_receiver assertion macros
// concurrent assertion wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every edge outside reset
`define FPR_ASSERT(label, clk, rstn, prop) \
	label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("fpr assertion failed");

// consequent must hold in the cycle after the antecedent
`define FPR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("fpr assertion failed");

`else

`define FPR_ASSERT(label, clk, rstn, prop)
`define FPR_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: hw/rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// types, codes and helpers shared by the frame receiver files
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 2;
	localparam int TICK_W    = 16;
	localparam int POS_W     = 9;
	localparam int REG_IDX_W = 2;
	localparam int REG_W     = 16;

	localparam logic [BYTE_W-1:0] LAST_SEQ_RESET     = 8'hAA;
	localparam logic [TICK_W-1:0] IDLE_TIMEOUT_RESET = 16'd100;
	localparam logic [BYTE_W-1:0] MOD_BASE           = 8'd255;

	// header bytes sit at fixed positions after the two sync bytes
	localparam logic [POS_W-1:0] POS_LENGTH  = 9'd2;
	localparam logic [POS_W-1:0] POS_SEQ     = 9'd3;
	localparam logic [POS_W-1:0] POS_OPCODE  = 9'd4;
	localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd5;

	typedef enum logic [1:0] {
		PH_HUNT1 = 2'd0,
		PH_HUNT2 = 2'd1,
		PH_READ  = 2'd2
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_ACCEPT  = 2'd1,
		KIND_DUP     = 2'd2,
		KIND_BAD_SUM = 2'd3
	} kind_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SYNC_FIRST   = 2'd0,
		REG_SYNC_SECOND  = 2'd1,
		REG_IDLE_TIMEOUT = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_idx_t;

	// (a + b) mod 255 for a < 255; the sum stays below twice the base
	function automatic logic [BYTE_W-1:0] add_mod255(
		input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] b
	);
		logic [BYTE_W:0] s;
		logic [BYTE_W:0] t;
		s = {1'b0, a} + {1'b0, b};
		t = s - {1'b0, MOD_BASE};
		return (s >= {1'b0, MOD_BASE}) ? t[BYTE_W-1:0] : s[BYTE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fpr_if.sv
// ----------------------------------------------------------------------------
// fpr_if
// valid/ready channels for received words and frame results
// ----------------------------------------------------------------------------
`default_nettype none

interface fpr_item_if;
	import fpr_pkg::*;

	logic              valid;
	logic              ready;
	logic              command;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface fpr_result_if;
	import fpr_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] payload_byte;
	logic [BYTE_W-1:0] frame_opcode;
	logic [BYTE_W-1:0] frame_seq;
	logic [BYTE_W-1:0] frame_length;

	modport source (
		output valid, output kind, output payload_byte, output frame_opcode,
		output frame_seq, output frame_length, input ready
	);
	modport sink (
		input valid, input kind, input payload_byte, input frame_opcode,
		input frame_seq, input frame_length, output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/framed_packet_receiver.sv
// Framed packet receiver. Each input word is either a received UART byte or a
// one millisecond tick. The block hunts for the two sync bytes, then reads
// length, sequence and opcode, passes each payload byte on as a result, and
// after the two Fletcher-16 check bytes (low first, mod-255 sums over all bytes
// from the first sync byte) gives one verdict: accepted, duplicate sequence or
// bad checksum. A duplicate sequence wins over a bad checksum; only accepted
// frames update the remembered sequence, which starts at 0xAA. Ticks count idle
// time; once the count passes idle_timeout a partial frame is dropped. Rate is
// one word per clock unless stalled: a word is taken into an input register, and
// once the result register is free a single pass of byte-wide logic updates the
// frame state and loads the result register. The only stall comes from the
// result register: while it holds an untaken result and the input register holds
// a word, no new word is taken. Configuration writes must be made while no frame
// is in flight.
`default_nettype none

`include "framed_packet_receiver_assert.svh"

module framed_packet_receiver (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [fpr_pkg::REG_IDX_W-1:0]    wr_index,
	input  wire logic [fpr_pkg::REG_W-1:0]        wr_data,
	fpr_item_if.sink                              item,
	fpr_result_if.source                          result
);
	import fpr_pkg::*;

	// configuration
	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;
	logic [TICK_W-1:0] idle_timeout_q;

	// input register
	logic              valid_s1;
	logic              command_s1;
	logic [BYTE_W-1:0] byte_s1;

	// frame state
	phase_t            phase_q, phase_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [BYTE_W-1:0] sum_low_q, sum_low_d;
	logic [BYTE_W-1:0] sum_high_q, sum_high_d;
	logic [BYTE_W-1:0] length_q, length_d;
	logic [BYTE_W-1:0] seq_q, seq_d;
	logic [BYTE_W-1:0] opcode_q, opcode_d;
	logic [BYTE_W-1:0] check_low_q, check_low_d;
	logic [BYTE_W-1:0] last_seq_q, last_seq_d;
	logic [TICK_W-1:0] idle_q, idle_d;

	// result register
	logic              res_valid_q;
	kind_t             res_kind_q;
	logic [BYTE_W-1:0] res_payload_q;
	logic [BYTE_W-1:0] res_opcode_q;
	logic [BYTE_W-1:0] res_seq_q;
	logic [BYTE_W-1:0] res_length_q;

	logic              out_free;
	logic              advance;
	logic              emit;
	kind_t             emit_kind;
	logic [BYTE_W-1:0] emit_payload;
	logic [TICK_W-1:0] idle_inc;
	logic [BYTE_W-1:0] sum_low_add;
	logic [BYTE_W-1:0] sum_high_add;
	logic [POS_W-1:0]  check_pos;

	assign out_free   = !res_valid_q || result.ready;
	assign advance    = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q   <= '0;
			sync_second_q  <= '0;
			idle_timeout_q <= IDLE_TIMEOUT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_SYNC_FIRST:   sync_first_q   <= wr_data[BYTE_W-1:0];
				REG_SYNC_SECOND:  sync_second_q  <= wr_data[BYTE_W-1:0];
				REG_IDLE_TIMEOUT: idle_timeout_q <= wr_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			command_s1 <= item.command;
			byte_s1    <= item.rx_byte;
		end
	end

	// running check sums with the current byte folded in
	assign sum_low_add  = add_mod255(sum_low_q, byte_s1);
	assign sum_high_add = add_mod255(sum_high_q, sum_low_add);
	assign idle_inc     = (idle_q == '1) ? idle_q : idle_q + 1'b1;
	assign check_pos    = {1'b0, length_q} + POS_PAYLOAD;

	always_comb begin
		phase_d      = phase_q;
		pos_d        = pos_q;
		sum_low_d    = sum_low_q;
		sum_high_d   = sum_high_q;
		length_d     = length_q;
		seq_d        = seq_q;
		opcode_d     = opcode_q;
		check_low_d  = check_low_q;
		last_seq_d   = last_seq_q;
		idle_d       = idle_q;
		emit         = 1'b0;
		emit_kind    = KIND_PAYLOAD;
		emit_payload = '0;

		if (advance) begin
			if (command_s1) begin
				idle_d = idle_inc;
				if (idle_inc > idle_timeout_q) begin
					phase_d = PH_HUNT1;
					pos_d   = '0;
				end
			end else begin
				idle_d = '0;
				case (phase_q)
					PH_HUNT1, PH_HUNT2: begin
						if (byte_s1 == sync_first_q) begin
							// restart the sums with this byte alone
							sum_low_d  = add_mod255('0, byte_s1);
							sum_high_d = sum_low_d;
							pos_d      = 9'd1;
							phase_d    = PH_HUNT2;
						end else if (phase_q == PH_HUNT2 && byte_s1 == sync_second_q) begin
							sum_low_d  = sum_low_add;
							sum_high_d = sum_high_add;
							pos_d      = POS_LENGTH;
							phase_d    = PH_READ;
						end else begin
							phase_d = PH_HUNT1;
						end
					end
					PH_READ: begin
						pos_d = pos_q + 1'b1;
						if (pos_q == POS_LENGTH) begin
							length_d   = byte_s1;
							sum_low_d  = sum_low_add;
							sum_high_d = sum_high_add;
						end else if (pos_q == POS_SEQ) begin
							seq_d      = byte_s1;
							sum_low_d  = sum_low_add;
							sum_high_d = sum_high_add;
						end else if (pos_q == POS_OPCODE) begin
							opcode_d   = byte_s1;
							sum_low_d  = sum_low_add;
							sum_high_d = sum_high_add;
						end else if (pos_q < check_pos) begin
							sum_low_d    = sum_low_add;
							sum_high_d   = sum_high_add;
							emit         = 1'b1;
							emit_kind    = KIND_PAYLOAD;
							emit_payload = byte_s1;
						end else if (pos_q == check_pos) begin
							check_low_d = byte_s1;
						end else begin
							// high check byte closes the frame
							phase_d = PH_HUNT1;
							pos_d   = '0;
							emit    = 1'b1;
							if (seq_q == last_seq_q) begin
								emit_kind = KIND_DUP;
							end else if (sum_high_q != byte_s1 || sum_low_q != check_low_q) begin
								emit_kind = KIND_BAD_SUM;
							end else begin
								emit_kind  = KIND_ACCEPT;
								last_seq_d = seq_q;
							end
						end
					end
					default: begin
						phase_d = PH_HUNT1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT1;
			pos_q       <= '0;
			sum_low_q   <= '0;
			sum_high_q  <= '0;
			length_q    <= '0;
			seq_q       <= '0;
			opcode_q    <= '0;
			check_low_q <= '0;
			last_seq_q  <= LAST_SEQ_RESET;
			idle_q      <= '0;
		end else begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			sum_low_q   <= sum_low_d;
			sum_high_q  <= sum_high_d;
			length_q    <= length_d;
			seq_q       <= seq_d;
			opcode_q    <= opcode_d;
			check_low_q <= check_low_d;
			last_seq_q  <= last_seq_d;
			idle_q      <= idle_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// header fields come from the state after this word is taken in
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_kind_q    <= emit_kind;
			res_payload_q <= emit_payload;
			res_opcode_q  <= opcode_d;
			res_seq_q     <= seq_d;
			res_length_q  <= length_d;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.kind         = res_kind_q;
	assign result.payload_byte = res_payload_q;
	assign result.frame_opcode = res_opcode_q;
	assign result.frame_seq    = res_seq_q;
	assign result.frame_length = res_length_q;

	`FPR_ASSERT(a_stall_cause, clk, arst_n, !item.ready |-> (valid_s1 && res_valid_q && !result.ready))
	`FPR_ASSERT(a_sum_low_range, clk, arst_n, sum_low_q != MOD_BASE && sum_high_q != MOD_BASE)
	`FPR_ASSERT_NEXT(a_verdict_rehunt, clk, arst_n, advance && emit && emit_kind != KIND_PAYLOAD, phase_q == PH_HUNT1 && pos_q == '0)
	`FPR_ASSERT_NEXT(a_accept_seq, clk, arst_n, advance && emit && emit_kind == KIND_ACCEPT, last_seq_q == $past(seq_q))

endmodule

`default_nettype wire

// File: sim/tb_framed_packet_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_framed_packet_receiver
// Feeds framed byte streams and idle ticks through the receiver under several
// sync and timeout settings. A behavioral deframer predicts every payload byte
// and verdict, and each result taken from the block is compared in order.
// ----------------------------------------------------------------------------
module tb_framed_packet_receiver;
	import fpr_pkg::*;

	localparam int   CLK_PERIOD    = 20;
	localparam int   CYCLE_LIMIT   = 200000;
	localparam int   SETTLE_CYCLES = 8;
	localparam int   HOLD_CYCLES   = 400;
	localparam logic CMD_BYTE      = 1'b0;
	localparam logic CMD_TICK      = 1'b1;

	typedef struct packed {
		logic              command;
		logic [BYTE_W-1:0] rx_byte;
	} rx_word_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] opcode;
		logic [BYTE_W-1:0] seq;
		logic [BYTE_W-1:0] length;
	} frame_event_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [REG_W-1:0]     wr_data;

	fpr_item_if   item_ch ();
	fpr_result_if result_ch ();

	framed_packet_receiver u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	// deframer state as the block should hold it
	phase_t            rx_phase;
	logic [POS_W-1:0]  frame_pos;
	logic [BYTE_W-1:0] fl_low;
	logic [BYTE_W-1:0] fl_high;
	logic [BYTE_W-1:0] hdr_len;
	logic [BYTE_W-1:0] hdr_seq;
	logic [BYTE_W-1:0] hdr_op;
	logic [BYTE_W-1:0] chk_lo;
	logic [BYTE_W-1:0] prev_seq;
	logic [TICK_W-1:0] idle_count;
	logic [BYTE_W-1:0] cfg_sync_a;
	logic [BYTE_W-1:0] cfg_sync_b;
	logic [TICK_W-1:0] cfg_timeout;

	rx_word_t     words_to_send[$];
	frame_event_t events_due[$];
	int           words_pushed = 0;
	int           words_taken  = 0;
	int           errors       = 0;
	int           cycles       = 0;
	int           send_gap_pct = 18;
	int           take_gap_pct = 18;
	int           holds_wanted = 0;
	int           holds_done   = 0;
	int           hold_left    = 0;
	logic [7:0]   gen_last_seq = 8'h00;

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic fold_into_sums(input logic [BYTE_W-1:0] b);
		fl_low  = 8'((int'(fl_low) + int'(b)) % 255);
		fl_high = 8'((int'(fl_high) + int'(fl_low)) % 255);
	endtask

	task automatic post_event(input kind_t kind, input logic [BYTE_W-1:0] b);
		events_due.push_back({kind, b, hdr_op, hdr_seq, hdr_len});
	endtask

	task automatic deframe_word(input logic cmd, input logic [BYTE_W-1:0] b);
		int pos;
		if (cmd == CMD_TICK) begin
			if (idle_count != 16'hFFFF)
				idle_count++;
			if (idle_count > cfg_timeout) begin
				rx_phase  = PH_HUNT1;
				frame_pos = '0;
			end
		end else if (rx_phase != PH_READ) begin
			idle_count = '0;
			// a first sync byte always restarts the hunt
			if (b == cfg_sync_a) begin
				fl_low    = '0;
				fl_high   = '0;
				fold_into_sums(b);
				frame_pos = 9'd1;
				rx_phase  = PH_HUNT2;
			end else if (rx_phase == PH_HUNT2 && b == cfg_sync_b) begin
				fold_into_sums(b);
				frame_pos = 9'd2;
				rx_phase  = PH_READ;
			end else begin
				rx_phase = PH_HUNT1;
			end
		end else begin
			idle_count = '0;
			pos        = int'(frame_pos);
			frame_pos  = frame_pos + 9'd1;
			if (pos == 2) begin
				hdr_len = b;
				fold_into_sums(b);
			end else if (pos == 3) begin
				hdr_seq = b;
				fold_into_sums(b);
			end else if (pos == 4) begin
				hdr_op = b;
				fold_into_sums(b);
			end else if (pos < 5 + int'(hdr_len)) begin
				fold_into_sums(b);
				post_event(KIND_PAYLOAD, b);
			end else if (pos == 5 + int'(hdr_len)) begin
				chk_lo = b;
			end else begin
				rx_phase  = PH_HUNT1;
				frame_pos = '0;
				// a repeated sequence wins over a bad check value
				if (hdr_seq == prev_seq) begin
					post_event(KIND_DUP, 8'h00);
				end else if ({fl_high, fl_low} != {b, chk_lo}) begin
					post_event(KIND_BAD_SUM, 8'h00);
				end else begin
					prev_seq = hdr_seq;
					post_event(KIND_ACCEPT, 8'h00);
				end
			end
		end
	endtask

	// word driver
	always @(posedge clk or negedge arst_n) begin : drive_words
		rx_word_t w;
		if (!arst_n) begin
			item_ch.valid   <= 1'b0;
			item_ch.command <= CMD_BYTE;
			item_ch.rx_byte <= '0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				deframe_word(item_ch.command, item_ch.rx_byte);
				words_taken++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (words_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					w = words_to_send.pop_front();
					item_ch.valid   <= 1'b1;
					item_ch.command <= w.command;
					item_ch.rx_byte <= w.rx_byte;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin : check_results
		frame_event_t got;
		frame_event_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got = {result_ch.kind, result_ch.payload_byte, result_ch.frame_opcode,
					result_ch.frame_seq, result_ch.frame_length};
				if (events_due.size() == 0) begin
					$display("%0t: unexpected result kind/byte/op/seq/len %0d/%02h/%02h/%02h/%02h",
						$time, got.kind, got.payload_byte, got.opcode, got.seq, got.length);
					errors++;
				end else begin
					want = events_due.pop_front();
					if (got !== want) begin
						// fields in order kind/byte/op/seq/len
						$display("%0t: expected %0d/%02h/%02h/%02h/%02h got %0d/%02h/%02h/%02h/%02h",
							$time, want.kind, want.payload_byte, want.opcode, want.seq,
							want.length, got.kind, got.payload_byte, got.opcode, got.seq,
							got.length);
						errors++;
					end
				end
			end
			if (holds_done != holds_wanted) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= take_gap_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic push_word(input logic cmd, input logic [BYTE_W-1:0] b);
		words_to_send.push_back({cmd, b});
		words_pushed++;
	endtask

	// fill < 0 gives random payload; cut < 0 sends the whole frame
	task automatic send_frame(input int len, input logic [7:0] seq, input logic [7:0] op,
			input int fill, input bit corrupt, input int cut, input int stall_at,
			input int stall_ticks);
		logic [7:0] frame_bytes[$];
		logic [7:0] flip;
		int         s1;
		int         s2;
		frame_bytes = {cfg_sync_a, cfg_sync_b, 8'(len), seq, op};
		for (int i = 0; i < len; i++)
			frame_bytes.push_back(fill < 0 ? 8'($urandom_range(255)) : 8'(fill));
		s1 = 0;
		s2 = 0;
		foreach (frame_bytes[i]) begin
			s1 = (s1 + int'(frame_bytes[i])) % 255;
			s2 = (s2 + s1) % 255;
		end
		flip = corrupt ? 8'($urandom_range(1, 255)) : 8'h00;
		if ($urandom_range(1) == 0) begin
			frame_bytes.push_back(8'(s1) ^ flip);
			frame_bytes.push_back(8'(s2));
		end else begin
			frame_bytes.push_back(8'(s1));
			frame_bytes.push_back(8'(s2) ^ flip);
		end
		foreach (frame_bytes[i]) begin
			if (i == cut)
				break;
			if (i == stall_at)
				repeat (stall_ticks) push_word(CMD_TICK, 8'($urandom_range(255)));
			push_word(CMD_BYTE, frame_bytes[i]);
		end
		gen_last_seq = seq;
	endtask

	task automatic random_traffic(input int budget);
		int         used;
		int         pick;
		int         len;
		int         total;
		int         cut;
		int         stall_at;
		int         max_ticks;
		logic [7:0] seq;
		used = 0;
		while (used < budget) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				len       = ($urandom_range(59) == 0) ? $urandom_range(11, 255)
					: $urandom_range(10);
				total     = len + 7;
				seq       = ($urandom_range(99) < 30) ? gen_last_seq : 8'($urandom_range(255));
				cut       = ($urandom_range(99) < 8) ? $urandom_range(1, total - 1) : -1;
				stall_at  = ($urandom_range(99) < 12) ? $urandom_range(2, total - 1) : -1;
				max_ticks = (cfg_timeout < 6) ? int'(cfg_timeout) + 2 : 6;
				send_frame(len, seq, 8'($urandom_range(255)), -1, $urandom_range(99) < 15,
					cut, stall_at, $urandom_range(1, max_ticks));
				used += total;
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(3))
						0: push_word(CMD_BYTE, cfg_sync_a);
						1: push_word(CMD_BYTE, cfg_sync_b);
						default: push_word(CMD_BYTE, 8'($urandom_range(255)));
					endcase
				end
			end else begin
				repeat ($urandom_range(1, 4)) push_word(CMD_TICK, 8'($urandom_range(255)));
			end
		end
	endtask

	// let everything drain; a frame left open is finished with filler bytes
	task automatic quiesce();
		while (words_taken != words_pushed) @(posedge clk);
		while (rx_phase == PH_READ) begin
			push_word(CMD_BYTE, 8'($urandom_range(255)));
			while (words_taken != words_pushed) @(posedge clk);
		end
		while (events_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [7:0] first, input logic [7:0] second,
			input logic [15:0] timeout);
		@(posedge clk);
		wr_en      <= 1'b1;
		wr_index   <= REG_SYNC_FIRST;
		wr_data    <= {8'($urandom_range(255)), first};
		cfg_sync_a  = first;
		@(posedge clk);
		wr_index   <= REG_SYNC_SECOND;
		wr_data    <= {8'($urandom_range(255)), second};
		cfg_sync_b  = second;
		@(posedge clk);
		wr_index    <= REG_IDLE_TIMEOUT;
		wr_data     <= timeout;
		cfg_timeout  = timeout;
		// writes to the spare index must be dropped
		@(posedge clk);
		wr_index <= REG_UNUSED;
		wr_data  <= 16'($urandom_range(65535));
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	initial begin
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		wr_index        = REG_SYNC_FIRST;
		wr_data         = '0;
		item_ch.valid   = 1'b0;
		item_ch.command = CMD_BYTE;
		item_ch.rx_byte = '0;
		result_ch.ready = 1'b0;
		rx_phase        = PH_HUNT1;
		frame_pos       = '0;
		fl_low          = '0;
		fl_high         = '0;
		hdr_len         = '0;
		hdr_seq         = '0;
		hdr_op          = '0;
		chk_lo          = '0;
		prev_seq        = LAST_SEQ_RESET;
		idle_count      = '0;
		cfg_sync_a      = '0;
		cfg_sync_b      = '0;
		cfg_timeout     = IDLE_TIMEOUT_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: both sync values zero, so no frame is ever entered
		push_word(CMD_BYTE, 8'h00);
		push_word(CMD_BYTE, 8'h00);
		push_word(CMD_TICK, 8'hFF);
		push_word(CMD_BYTE, 8'hFF);
		quiesce();

		program_regs(8'hA5, 8'h5A, 16'd3);
		// sequence equal to the reset value is a duplicate
		send_frame(0, LAST_SEQ_RESET, 8'h00, -1, 1'b0, -1, -1, 0);
		send_frame(1, 8'h01, 8'h00, 8'hFF, 1'b0, -1, -1, 0);
		// duplicate with a bad check value still reports duplicate
		send_frame(0, 8'h01, 8'hFF, -1, 1'b1, -1, -1, 0);
		// wrong second byte, then a repeated first sync and an idle gap
		push_word(CMD_BYTE, 8'hA5);
		push_word(CMD_BYTE, 8'h33);
		push_word(CMD_BYTE, 8'hA5);
		push_word(CMD_BYTE, 8'hA5);
		push_word(CMD_BYTE, 8'h5A);
		repeat (4) push_word(CMD_TICK, 8'h00);
		random_traffic(30);
		quiesce();

		// stretch with no idling on either side
		program_regs(8'hFF, 8'h00, 16'd0);
		send_gap_pct = 0;
		take_gap_pct = 0;
		random_traffic(25);
		quiesce();
		send_gap_pct = 18;
		take_gap_pct = 18;

		// long receiver hold-off over the largest frame
		program_regs(8'h00, 8'hFF, 16'hFFFF);
		holds_wanted++;
		send_frame(255, 8'($urandom_range(255)), 8'($urandom_range(255)), -1, 1'b0, -1, -1, 0);
		random_traffic(20);
		quiesce();

		program_regs(8'h07, 8'h07, IDLE_TIMEOUT_RESET);
		random_traffic(15);
		quiesce();

		program_regs(8'h12, 8'h34, 16'd10);
		random_traffic(30);
		quiesce();

		if (errors == 0 && events_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
